FILE: hdl/nf_pkg.sv
// Package for the n-gram dictionary token filter.
// Holds operation, mode and register codes and the dictionary command struct.
// No dependencies.
`default_nettype none
package nf_pkg;

    localparam int TOKEN_W = 32;

    // Input operation codes
    localparam logic [1:0] OP_TEXT  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Selection modes
    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_PAD   = 2'd1;
    localparam logic [1:0] REG_WLEFT = 2'd2;
    localparam logic [1:0] REG_WRIGHT = 2'd3;

    // Dictionary load and clear command
    typedef struct packed {
        logic                 load;
        logic                 clear;
        logic [TOKEN_W-1:0]   token;
        logic                 last;
    } t_dict_cmd;

endpackage
`default_nettype wire

FILE: hdl/nf_if.sv
// Channel interfaces of the n-gram dictionary token filter.
// Input, output and configuration channels; depends on nothing.
`default_nettype none
interface nf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] token;
    logic        last;
    modport source (output valid, op, token, last, input ready);
    modport sink   (input valid, op, token, last, output ready);
endinterface

interface nf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_token;
    logic        has_token;
    logic        end_of_text;
    modport source (output valid, out_token, has_token, end_of_text, input ready);
    modport sink   (input valid, out_token, has_token, end_of_text, output ready);
endinterface

interface nf_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/nf_dict.sv
// Dictionary store: assembles n-grams token by token and writes whole rows.
// Depends on nf_pkg.
`default_nettype none
module nf_dict #(
    parameter int MAX_SPAN     = 4,
    parameter int DICT_ENTRIES = 256,
    parameter int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1,
    parameter int CW = $clog2(DICT_ENTRIES + 1),
    parameter int LW = $clog2(MAX_SPAN + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire nf_pkg::t_dict_cmd      i_cmd,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic [MAX_SPAN*32-1:0]      o_rd_tokens,
    output logic [LW-1:0]               o_rd_len,
    output logic [CW-1:0]               o_count
);
    localparam int ROW_W = MAX_SPAN * 32 + LW;

    logic [ROW_W-1:0]         mem [DICT_ENTRIES];
    logic [MAX_SPAN*32-1:0]   r_buf, n_buf;
    logic [LW-1:0]            r_pos, n_pos;
    logic                     r_over, n_over;
    logic [CW-1:0]            r_count, n_count;
    logic                     n_we;
    logic [ROW_W-1:0]         r_rd;

    // Load and clear sequencing: buffer tokens, commit the row on the final token unless overlong or full.
    always_comb begin
        n_buf   = r_buf;
        n_pos   = r_pos;
        n_over  = r_over;
        n_count = r_count;
        n_we    = 1'b0;
        if (i_cmd.clear) begin
            n_pos   = '0;
            n_over  = 1'b0;
            n_count = '0;
        end else if (i_cmd.load) begin
            if (r_pos < LW'(MAX_SPAN)) begin
                for (int j = 0; j < MAX_SPAN; j++) begin
                    if (r_pos == LW'(j)) n_buf[j*32 +: 32] = i_cmd.token;
                end
                n_pos = r_pos + 1'b1;
            end else begin
                n_over = 1'b1;
            end
            if (i_cmd.last) begin
                if (!n_over && (r_count < CW'(DICT_ENTRIES))) begin
                    n_we    = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_pos  = '0;
                n_over = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_over  <= 1'b0;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_over  <= n_over;
            r_count <= n_count;
        end
        r_buf <= n_buf;
    end

    // Row memory with one write port and one registered read port.
    // The stored length is the buffered count including the final token.
    always_ff @(posedge i_clk) begin
        if (n_we) mem[r_count[AW-1:0]] <= {r_pos + LW'(1), n_buf};
        r_rd <= mem[i_rd_addr];
    end

    assign o_rd_tokens = r_rd[MAX_SPAN*32-1:0];
    assign o_rd_len    = r_rd[ROW_W-1 -: LW];
    assign o_count     = r_count;
endmodule
`default_nettype wire

FILE: hdl/ngram_dictionary_token_filter.sv
// Top level of the n-gram dictionary token filter: sequencer, token history,
// mark line, shared row compare and result output. Depends on nf_pkg, nf_if, nf_dict.
//
//  Channel   Dir  Payload                              Handshake
//  i_in      in   op, token, last                      valid / ready
//  o_out     out  out_token, has_token, end_of_text    valid / ready
//  i_cfg     in   index, data                          valid / ready (always ready)
//
// Dictionary operations are applied as they are accepted. A text token is accepted,
// then the row memory is scanned, one row compared per cycle, then the marks are
// set and the result slots are walked; the final token of a text walks up to the
// left window plus MAX_SPAN slots.
// Synchronous active-low reset empties the dictionary and the marks.
// A stalled output holds the emit step in place.
`default_nettype none
module ngram_dictionary_token_filter #(
    parameter int MAX_SPAN     = 4,
    parameter int MAX_WINDOW   = 8,
    parameter int DICT_ENTRIES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nf_in_if.sink     i_in,
    nf_out_if.source  o_out,
    nf_cfg_if.sink    i_cfg
);
    localparam int H  = MAX_WINDOW + MAX_SPAN;
    localparam int MV = MAX_WINDOW + H;
    localparam int KW = (H > 1) ? $clog2(H) : 1;
    localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int CW = $clog2(DICT_ENTRIES + 1);
    localparam int LW = $clog2(MAX_SPAN + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK, S_EMIT} t_state;

    t_state            r_state;
    logic [31:0]       r_hist [H];
    logic [MV-1:0]     r_mark;
    logic [15:0]       r_n;
    logic [1:0]        r_cmode, r_mode;
    logic              r_cpad, r_pad;
    logic [3:0]        r_cwl, r_cwr;
    logic [4:0]        r_wl, r_wr;
    logic              r_last, r_flush, r_any;
    logic [CW-1:0]     r_idx;
    logic              r_rdv;
    logic [LW-1:0]     r_smax;
    logic [KW-1:0]     r_k;
    logic              r_ov, r_ohas, r_oeot;
    logic [31:0]       r_otok;

    nf_pkg::t_dict_cmd       dcmd;
    logic [MAX_SPAN*32-1:0]  rd_tokens;
    logic [LW-1:0]           rd_len;
    logic [CW-1:0]           dcount;
    logic                    in_acc, slot_free, row_match, emit_now;
    logic [H-1:0]            pv, ev;
    logic [MV-1:0]           set_mark;
    logic                    lower;
    int                      hi, dd;

    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_ov || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Dictionary commands from the input channel.
    always_comb begin
        dcmd.load  = in_acc && (i_in.op == nf_pkg::OP_LOAD);
        dcmd.clear = in_acc && (i_in.op == nf_pkg::OP_CLEAR);
        dcmd.token = i_in.token;
        dcmd.last  = i_in.last;
    end

    nf_dict #(.MAX_SPAN(MAX_SPAN), .DICT_ENTRIES(DICT_ENTRIES)) u_dict (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dcmd),
        .i_rd_addr  (r_idx[AW-1:0]),
        .o_rd_tokens(rd_tokens),
        .o_rd_len   (rd_len),
        .o_count    (dcount)
    );

    // Shared compare: one dictionary row against the most recent tokens.
    always_comb begin
        row_match = (rd_len != '0) && ({{(16-LW){1'b0}}, rd_len} <= r_n);
        for (int j = 0; j < MAX_SPAN; j++) begin
            if (LW'(j) < rd_len) begin
                if (rd_tokens[j*32 +: 32] != r_hist[KW'(int'(rd_len) - 1 - j)])
                    row_match = 1'b0;
            end
        end
    end

    // Covered range for the longest matched span, and the emit delay.
    always_comb begin
        hi = int'(r_smax) - 1 + int'(r_wl);
        if (int'(r_n) <= hi) hi = int'(r_n) - 1;
        dd = int'(r_wl) + MAX_SPAN - 1;
        for (int i = 0; i < MV; i++) begin
            set_mark[i] = (r_smax != '0) && (i - MAX_WINDOW >= -int'(r_wr))
                          && (i - MAX_WINDOW <= hi);
        end
    end

    // Pass and emit flags for each history slot.
    always_comb begin
        lower = 1'b0;
        for (int k = 0; k < H; k++) begin
            case (r_mode)
                nf_pkg::MODE_KEEP:   pv[k] = r_mark[MAX_WINDOW + k];
                nf_pkg::MODE_REMOVE: pv[k] = !r_mark[MAX_WINDOW + k];
                default:             pv[k] = 1'b1;
            endcase
            ev[k] = pv[k] || r_pad;
            if ((KW'(k) < r_k) && ev[k]) lower = 1'b1;
        end
    end

    // A result transaction is loaded in this cycle: a passed slot or the bare end marker.
    assign emit_now = (r_state == S_EMIT) && slot_free
                      && (ev[r_k] || (r_flush && (r_k == '0) && !r_any));

    // Sequencer, history, marks, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mark  <= '0;
            r_n     <= '0;
            r_cmode <= '0; r_cpad <= 1'b0; r_cwl <= '0; r_cwr <= '0;
            r_mode  <= '0; r_pad <= 1'b0; r_wl <= '0; r_wr <= '0;
            r_rdv   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    nf_pkg::REG_MODE:   r_cmode <= i_cfg.data[1:0];
                    nf_pkg::REG_PAD:    r_cpad  <= i_cfg.data[0];
                    nf_pkg::REG_WLEFT:  r_cwl   <= i_cfg.data;
                    nf_pkg::REG_WRIGHT: r_cwr   <= i_cfg.data;
                    default: ;
                endcase
            end

            // Output valid: set on a new result, cleared once the sink takes it.
            if (emit_now) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.op == nf_pkg::OP_TEXT)) begin
                        if (r_n == '0) begin
                            r_mode <= r_cmode;
                            r_pad  <= r_cpad;
                            r_wl   <= (int'(r_cwl) > MAX_WINDOW) ? 5'(MAX_WINDOW)
                                                                 : {1'b0, r_cwl};
                            r_wr   <= (int'(r_cwr) > MAX_WINDOW) ? 5'(MAX_WINDOW)
                                                                 : {1'b0, r_cwr};
                        end
                        r_hist[0] <= i_in.token;
                        for (int k = 1; k < H; k++) r_hist[k] <= r_hist[k-1];
                        r_mark <= r_mark << 1;
                        if (r_n != 16'hFFFF) r_n <= r_n + 1'b1;
                        r_last  <= i_in.last;
                        r_idx   <= '0;
                        r_rdv   <= 1'b0;
                        r_smax  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rdv && row_match && (rd_len > r_smax)) r_smax <= rd_len;
                    if (r_idx < dcount) begin
                        r_idx <= r_idx + 1'b1;
                        r_rdv <= 1'b1;
                    end else begin
                        r_rdv <= 1'b0;
                        if (!r_rdv) r_state <= S_MARK;
                    end
                end
                S_MARK: begin
                    r_mark <= r_mark | set_mark;
                    r_any  <= 1'b0;
                    if (r_last) begin
                        r_flush <= 1'b1;
                        r_k     <= (int'(r_n) - 1 < dd) ? KW'(int'(r_n) - 1) : KW'(dd);
                        r_state <= S_EMIT;
                    end else if (int'(r_n) > dd) begin
                        r_flush <= 1'b0;
                        r_k     <= KW'(dd);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        if (ev[r_k]) begin
                            r_otok <= pv[r_k] ? r_hist[r_k] : 32'd0;
                            r_ohas <= 1'b1;
                            r_oeot <= r_flush && !lower;
                            r_any  <= 1'b1;
                        end else if (r_flush && (r_k == '0) && !r_any) begin
                            r_otok <= 32'd0;
                            r_ohas <= 1'b0;
                            r_oeot <= 1'b1;
                        end
                        if (!r_flush || (r_k == '0)) begin
                            if (r_flush) begin
                                r_mark <= '0;
                                r_n    <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k - 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.out_token   = r_otok;
    assign o_out.has_token   = r_ohas;
    assign o_out.end_of_text = r_oeot;
endmodule
`default_nettype wire

FILE: bench/ngram_dictionary_token_filter_tb.sv
// Testbench for the n-gram dictionary token filter.
// Drives the input and configuration channels, predicts results, checks outputs.
// Depends on nf_pkg, nf_if and ngram_dictionary_token_filter.
`timescale 1ns / 1ps
module ngram_dictionary_token_filter_tb;

    localparam int SPAN = 4;
    localparam int WMAX = 8;
    localparam int ENTRIES = 256;
    localparam int WATCHDOG = 20000;
    localparam int RANDOM_ITEMS = 230;

    typedef struct packed {
        logic [31:0] tok;
        logic        has;
        logic        eot;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] tok;
        logic        last;
        logic        chk;
        t_result     want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    nf_in_if  in_ch ();
    nf_out_if out_ch ();
    nf_cfg_if cfg_ch ();

    ngram_dictionary_token_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    // Predictor state.
    logic [31:0] ent_tok [ENTRIES][SPAN];
    int          ent_len [ENTRIES];
    int          n_entries, load_pos;
    bit          load_long;
    logic [31:0] hist [64];
    bit          mark [64];
    int          pos, head;
    logic [1:0]  r_mode;
    logic        r_pad;
    logic [3:0]  r_wl, r_wr;
    logic [1:0]  txt_mode;
    logic        txt_pad;
    int          txt_wl, txt_wr;

    t_result expected_q [$];
    int      errors = 0;
    int      idle_cycles = 0;
    bit      allow_stall;

    function automatic int slot(int back);
        return (head - back) & 63;
    endfunction

    function automatic void emit_slot(int back);
        int  s;
        bit  pass;
        t_result r;
        s = slot(back);
        pass = (txt_mode == nf_pkg::MODE_KEEP) ? mark[s]
             : (txt_mode == nf_pkg::MODE_REMOVE) ? !mark[s] : 1'b1;
        mark[s] = 0;
        if (!pass && !txt_pad) return;
        r.tok = pass ? hist[s] : 32'd0;
        r.has = 1'b1;
        r.eot = 1'b0;
        expected_q.push_back(r);
    endfunction

    // Apply one accepted input item to the predictor.
    function automatic void predict_filter(logic [1:0] op, logic [31:0] tok, logic last);
        int d, hi, start;
        bit hit;
        t_result r;
        if (op == nf_pkg::OP_LOAD) begin
            if (load_pos < SPAN) begin
                if (n_entries < ENTRIES) ent_tok[n_entries][load_pos] = tok;
                load_pos++;
            end else load_long = 1;
            if (last) begin
                if (!load_long && n_entries < ENTRIES) begin
                    ent_len[n_entries] = load_pos;
                    n_entries++;
                end
                load_pos = 0;
                load_long = 0;
            end
            return;
        end
        if (op == nf_pkg::OP_CLEAR) begin
            n_entries = 0; load_pos = 0; load_long = 0;
            return;
        end
        if (op != nf_pkg::OP_TEXT) return;
        if (pos == 0) begin
            txt_mode = r_mode; txt_pad = r_pad;
            txt_wl = (r_wl > WMAX) ? WMAX : r_wl;
            txt_wr = (r_wr > WMAX) ? WMAX : r_wr;
        end
        head = (head + 1) & 63;
        hist[head] = tok;
        if (pos < 16'hFFFF) pos++;
        for (int s = 1; s <= SPAN && s <= pos; s++) begin
            for (int e = 0; e < n_entries; e++) begin
                if (ent_len[e] != s) continue;
                hit = 1;
                for (int j = 0; j < s; j++)
                    if (ent_tok[e][j] != hist[slot(s - 1 - j)]) hit = 0;
                if (!hit) continue;
                hi = s - 1 + txt_wl;
                if (hi > pos - 1) hi = pos - 1;
                for (int k = -txt_wr; k <= hi; k++) mark[slot(k)] = 1;
                break;
            end
        end
        d = txt_wl + SPAN - 1;
        if (!last) begin
            if (pos > d) emit_slot(d);
            return;
        end
        start = expected_q.size();
        for (int k = (pos - 1 < d ? pos - 1 : d); k >= 0; k--) emit_slot(k);
        if (expected_q.size() > start) begin
            expected_q[expected_q.size() - 1].eot = 1'b1;
        end else begin
            r.tok = 0; r.has = 0; r.eot = 1;
            expected_q.push_back(r);
        end
        for (int i = 0; i < 64; i++) mark[i] = 0;
        pos = 0;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Output sink: random ready bursts, check each transaction.
    int stall_left;
    initial begin
        out_ch.ready = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready = 0;
            end else if (allow_stall && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ch.ready = 0;
            end else out_ch.ready = 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: out_token %h", out_ch.out_token);
                errors++;
            end else begin
                t_result w;
                w = expected_q.pop_front();
                if (out_ch.out_token !== w.tok) begin
                    $error("out_token: expected %h, actual %h", w.tok, out_ch.out_token);
                    errors++;
                end
                if (out_ch.has_token !== w.has) begin
                    $error("has_token: expected %b, actual %b", w.has, out_ch.has_token);
                    errors++;
                end
                if (out_ch.end_of_text !== w.eot) begin
                    $error("end_of_text: expected %b, actual %b", w.eot, out_ch.end_of_text);
                    errors++;
                end
            end
        end
    end

    // Watchdog over cycles with no transaction.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] tok, logic last);
        int gap;
        if (allow_stall && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            in_ch.valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1;
        in_ch.op = op;
        in_ch.token = tok;
        in_ch.last = last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_filter(op, tok, last);
        @(negedge i_clk);
        in_ch.valid = 0;
    endtask

    // Wait until every expected result has come, then let the block settle.
    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_ch.valid = 1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            nf_pkg::REG_MODE:   r_mode = val[1:0];
            nf_pkg::REG_PAD:    r_pad = val[0];
            nf_pkg::REG_WLEFT:  r_wl = val;
            nf_pkg::REG_WRIGHT: r_wr = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 0;
    endtask

    task automatic set_config(logic [1:0] m, logic p, logic [3:0] wl, logic [3:0] wr);
        drain();
        write_reg(nf_pkg::REG_MODE, {2'b00, m});
        write_reg(nf_pkg::REG_PAD, {3'b000, p});
        write_reg(nf_pkg::REG_WLEFT, wl);
        write_reg(nf_pkg::REG_WRIGHT, wr);
    endtask

    function automatic logic [31:0] pick_token(int vocab);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return $urandom_range(1, vocab);
        endcase
    endfunction

    // Directed table: dictionary setup and short texts.
    t_row rows [$];
    function automatic t_row mk(logic [1:0] op, logic [31:0] tok, logic last,
                                logic chk = 0, t_result want = '0);
        t_row r;
        r.op = op; r.tok = tok; r.last = last; r.chk = chk; r.want = want;
        return r;
    endfunction

    initial begin
        int vocab, len, got;
        t_result w;
        allow_stall = 0;
        n_entries = 0; load_pos = 0; load_long = 0; pos = 0; head = 0;
        r_mode = 0; r_pad = 0; r_wl = 0; r_wr = 0;
        txt_mode = 0; txt_pad = 0; txt_wl = 0; txt_wr = 0;
        for (int i = 0; i < 64; i++) begin hist[i] = 0; mark[i] = 0; end
        in_ch.valid = 0; in_ch.op = nf_pkg::OP_TEXT; in_ch.token = 0; in_ch.last = 0;
        cfg_ch.valid = 0; cfg_ch.index = nf_pkg::REG_MODE; cfg_ch.data = 0;
        i_rst_n = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // After reset: keep mode, empty dictionary, no padding gives a bare end marker.
        w = '{tok: 0, has: 0, eot: 1};
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd5, 1, 1, w));
        rows.push_back(mk(nf_pkg::OP_LOAD, 32'hFFFF_FFFF, 1));   // one-token n-gram
        rows.push_back(mk(nf_pkg::OP_LOAD, 32'd0, 0));           // two-token n-gram
        rows.push_back(mk(nf_pkg::OP_LOAD, 32'd7, 1));
        for (int i = 0; i < 5; i++)
            rows.push_back(mk(nf_pkg::OP_LOAD, 32'd9, i == 4)); // overlong
        rows.push_back(mk(2'd3, 32'd1, 1));                      // ignored opcode
        w = '{tok: 32'hFFFF_FFFF, has: 1, eot: 1};
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'hFFFF_FFFF, 1, 1, w));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd3, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd0, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd7, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd9, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd9, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd9, 0));
        rows.push_back(mk(nf_pkg::OP_TEXT, 32'd9, 1));
        foreach (rows[i]) begin
            int prior_size;
            prior_size = expected_q.size();
            send_item(rows[i].op, rows[i].tok, rows[i].last);
            if (rows[i].chk && expected_q.size() == prior_size + 1)
                expected_q[prior_size] = rows[i].want;
        end

        // Extremes of the registers, including out-of-range window and selector 3.
        set_config(nf_pkg::MODE_REMOVE, 1, 4'd15, 4'd15);
        foreach (rows[i])
            if (rows[i].op == nf_pkg::OP_TEXT) send_item(rows[i].op, rows[i].tok, rows[i].last);
        set_config(2'd3, 0, 4'd8, 4'd0);
        foreach (rows[i])
            if (rows[i].op == nf_pkg::OP_TEXT) send_item(rows[i].op, rows[i].tok, rows[i].last);
        send_item(nf_pkg::OP_CLEAR, 32'd1, 0);

        // Fill past the dictionary capacity.
        for (int e = 0; e < ENTRIES + 4; e++) send_item(nf_pkg::OP_LOAD, 32'd100 + e, 1);
        send_item(nf_pkg::OP_TEXT, 32'd100, 0);
        send_item(nf_pkg::OP_TEXT, 32'd101, 1);
        send_item(nf_pkg::OP_CLEAR, 32'd1, 1);

        // Random phases: small dictionary, then texts with random content.
        allow_stall = 1;
        got = 0;
        for (int ph = 0; got < RANDOM_ITEMS; ph++) begin
            if (ph == 4) begin
                // Sender holds off until every expected result is in.
                drain();
            end
            if (ph % 2 == 1)
                set_config($urandom_range(0, 3), $urandom_range(0, 1),
                           $urandom_range(0, 15), $urandom_range(0, 15));
            vocab = $urandom_range(2, 6);
            if ($urandom_range(0, 2) == 0)
                send_item(nf_pkg::OP_CLEAR, $urandom(), $urandom_range(0, 1));
            for (int e = 0; e < $urandom_range(1, 4); e++) begin
                len = $urandom_range(1, (($urandom_range(0, 7) == 0) ? 6 : SPAN));
                for (int j = 0; j < len; j++)
                    send_item(nf_pkg::OP_LOAD, pick_token(vocab), j == len - 1);
            end
            for (int t = 0; t < 3; t++) begin
                len = $urandom_range(1, 14);
                for (int j = 0; j < len; j++) begin
                    send_item(nf_pkg::OP_TEXT, pick_token(vocab), j == len - 1);
                    got++;
                end
            end
            if (got > RANDOM_ITEMS - 30) allow_stall = 0;
        end

        // Final wait with a limit.
        for (int c = 0; c < WATCHDOG && expected_q.size() != 0; c++) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
